@@ rtl/deq_pkg.sv @@
// Shared types and codes of the double-ended queue.
package deq_pkg;

  localparam logic [1:0] OP_PUSH_R = 2'd0;
  localparam logic [1:0] OP_POP_L  = 2'd1;
  localparam logic [1:0] OP_POP_R  = 2'd2;
  localparam logic [1:0] OP_PEEK   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] item_value;
  } deq_in_t;

  typedef struct packed {
    logic [31:0] popped_value;
    logic [31:0] left_value;
    logic [31:0] right_value;
    logic        is_empty;
    logic [4:0]  occupancy;
    logic [1:0]  status;
  } deq_out_t;

  // Decoded command handed from the front part to the back part.
  typedef struct packed {
    logic        push;
    logic        pop_left;
    logic        pop_right;
    logic [31:0] data;
  } deq_cmd_t;

endpackage

@@ rtl/deq_front.sv @@
// Request decoder and two-entry command queue feeding the back engine.
module deq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::deq_in_t   in_data,
  output logic               cmd_valid,
  output deq_pkg::deq_cmd_t  cmd,
  input  logic               cmd_take
);

  localparam int unsigned QDEPTH = 2;

  deq_pkg::deq_cmd_t q_r [QDEPTH];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              accept;
  deq_pkg::deq_cmd_t dec;

  // decode the operation into command flags, at most one set (none for a peek)
  always_comb begin
    dec           = '0;
    dec.data      = in_data.item_value;
    unique case (in_data.operation)
      deq_pkg::OP_PUSH_R: dec.push      = 1'b1;
      deq_pkg::OP_POP_L:  dec.pop_left  = 1'b1;
      deq_pkg::OP_POP_R:  dec.pop_right = 1'b1;
      deq_pkg::OP_PEEK:   ;
      default:            ;
    endcase
  end

  assign busy      = (cnt_r == 2'(QDEPTH));
  assign accept    = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_take ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(accept) - 2'(cmd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

@@ rtl/deq_back.sv @@
// Ring store, end-word cache and operation engine of the queue.
module deq_back #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  deq_pkg::deq_cmd_t  cmd,
  output logic               cmd_take,
  output logic               out_valid,
  output deq_pkg::deq_out_t  out_data
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FILL = 1'b1;

  logic [WORD_WIDTH-1:0] store_r [DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_r;
  logic [WORD_WIDTH-1:0] left_r, left_nxt;
  logic [WORD_WIDTH-1:0] right_r, right_nxt;
  logic [WORD_WIDTH-1:0] popped_r, popped_nxt;
  logic [WORD_WIDTH-1:0] item_w;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      count_m2;
  logic                  state_r, state_nxt;
  logic                  fill_left_r, fill_left_nxt;
  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_idx, rd_idx;
  logic                  emit;
  logic [1:0]            status;
  logic                  full, empty;
  logic                  out_valid_r;
  deq_pkg::deq_out_t     out_r, out_nxt;

  function automatic logic [IDX_W-1:0] ring(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] offset);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign item_w   = WORD_WIDTH'(cmd.data);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign count_m2 = count_r - CNT_W'(2);
  assign cmd_take = (state_r == S_IDLE) && cmd_valid;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    popped_nxt    = popped_r;
    fill_left_nxt = fill_left_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    wr_idx        = ring(head_r, count_r[IDX_W-1:0]);
    rd_idx        = head_r;
    emit          = 1'b0;
    status        = deq_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        popped_nxt = '0;
        if (cmd_take) begin
          if (cmd.push) begin
            emit = 1'b1;
            if (full) begin
              status = deq_pkg::ST_OVER;
            end else begin
              wr_en     = 1'b1;
              right_nxt = item_w;
              if (empty) begin
                left_nxt = item_w;
              end
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (cmd.pop_left || cmd.pop_right) begin
            if (empty) begin
              emit   = 1'b1;
              status = deq_pkg::ST_UNDER;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              if (cmd.pop_left) begin
                popped_nxt = left_r;
                head_nxt   = ring(head_r, IDX_W'(1));
                rd_idx     = head_nxt;
              end else begin
                popped_nxt = right_r;
                rd_idx     = ring(head_r, count_m2[IDX_W-1:0]);
              end
              // refetch the new end word unless the queue drains
              if (count_nxt == '0) begin
                emit = 1'b1;
              end else begin
                rd_en         = 1'b1;
                fill_left_nxt = cmd.pop_left;
                state_nxt     = S_FILL;
              end
            end
          end else begin
            emit = 1'b1;
          end
        end
      end
      S_FILL: begin
        if (fill_left_r) begin
          left_nxt = rd_data_r;
        end else begin
          right_nxt = rd_data_r;
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt              = '0;
    out_nxt.popped_value = 32'(popped_nxt);
    out_nxt.is_empty     = (count_nxt == '0);
    out_nxt.occupancy    = 5'(count_nxt);
    out_nxt.status       = status;
    if (count_nxt != '0) begin
      out_nxt.left_value  = 32'(left_nxt);
      out_nxt.right_value = 32'(right_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    popped_r    <= popped_nxt;
    fill_left_r <= fill_left_nxt;
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= item_w;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_idx];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/double_ended_queue.sv @@
// Top level of the double-ended queue: command front end and ring-store engine.
// A request is taken on a rising edge with start high and busy low; it asks
// to push a word on the right, pop from the left, pop from the right, or
// peek. Every request yields exactly one result, shown for a single cycle
// with out_valid high; the receiver must take it then, as results cannot be
// held off. The result carries the popped word (zero if none), the leftmost
// and rightmost words after the operation (zero when empty), an empty flag,
// the occupancy and a status: ok, underflow (pop of an empty queue, nothing
// changes) or overflow (push onto a full queue, the word is dropped).
// Requests enter a two-entry command queue; busy is high while it is full.
// The engine finishes a push, a peek, a rejected pop or a pop that empties
// the queue in its idle state; a pop that leaves words behind also passes
// through a fill state, as the new end word comes out of the ring store
// through its single registered read port. The engine takes no new command
// while it is in the fill state. The store is never cleared; only entries
// that were pushed are ever read.
module double_ended_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  output deq_pkg::deq_out_t out_data
);

  logic              cmd_valid;
  logic              cmd_take;
  deq_pkg::deq_cmd_t cmd;

  // decode requests and buffer them ahead of the engine
  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // carry out one command at a time against the ring store
  deq_back #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
